@@ rtl/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants for the command stream credit control block.
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_MAX_TEXT    = 120;

  localparam int unsigned ID_W       = 32;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned TEXT_W     = 8;
  localparam int unsigned LIMIT_W    = 8;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd127;
  localparam logic               LINK_RESET  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_RECEIVE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_ACTIVE   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ISSUE  = 2'd0,
    CMD_OK     = 2'd1,
    CMD_FAULT  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef struct packed {
    logic             accepted;
    logic [ID_W-1:0]  assigned_id;
    logic             queue_full;
    logic             send_valid;
    logic [ID_W-1:0]  send_id;
    logic [LEN_W-1:0] send_length;
    logic             done_valid;
    logic [ID_W-1:0]  done_id;
    logic             done_error;
    logic             stray_reply;
  } result_t;

endpackage

@@ rtl/csc_len_store.sv @@
// ----------------------------------------------------------------------------
// csc_len_store
// Length store of the command queue: one write port and two registered read
// ports, with write-through forwarding when a read hits the written entry.
// ----------------------------------------------------------------------------
module csc_len_store #(
  parameter int unsigned DEPTH = csc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic [csc_pkg::LEN_W-1:0] wr_data,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr_b,
  output logic [csc_pkg::LEN_W-1:0] rd_data_a,
  output logic [csc_pkg::LEN_W-1:0] rd_data_b
);

  logic [csc_pkg::LEN_W-1:0] len_mem_r [DEPTH];
  logic [csc_pkg::LEN_W-1:0] rd_a_r;
  logic [csc_pkg::LEN_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      len_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr_a)) begin
      rd_a_r <= wr_data;
    end else begin
      rd_a_r <= len_mem_r[rd_addr_a];
    end
    if (wr_en && (wr_addr == rd_addr_b)) begin
      rd_b_r <= wr_data;
    end else begin
      rd_b_r <= len_mem_r[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

@@ rtl/csc_step.sv @@
// ----------------------------------------------------------------------------
// csc_step
// Next-state and result logic for one beat: issue, completion and the single
// send attempt that follows, plus the prefetch addresses for the length store.
// ----------------------------------------------------------------------------
module csc_step #(
  parameter int unsigned DEPTH    = csc_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned MAX_TEXT = csc_pkg::DEF_MAX_TEXT
) (
  input  logic                          item_valid,
  input  logic [csc_pkg::CMD_W-1:0]     command,
  input  logic [csc_pkg::TEXT_W-1:0]    text_length,
  input  logic [csc_pkg::LIMIT_W-1:0]   receive_limit,
  input  logic                          link_active,
  input  logic [$clog2(DEPTH)-1:0]      head_r,
  input  logic [$clog2(DEPTH+1)-1:0]    entry_r,
  input  logic [$clog2(DEPTH+1)-1:0]    sent_r,
  input  logic [csc_pkg::LIMIT_W-1:0]   outstanding_r,
  input  logic [csc_pkg::ID_W-1:0]      last_id_r,
  input  logic [csc_pkg::LEN_W-1:0]     rd_len_a,
  input  logic [csc_pkg::LEN_W-1:0]     rd_len_b,
  output logic [$clog2(DEPTH)-1:0]      head_nxt,
  output logic [$clog2(DEPTH+1)-1:0]    entry_nxt,
  output logic [$clog2(DEPTH+1)-1:0]    sent_nxt,
  output logic [csc_pkg::LIMIT_W-1:0]   outstanding_nxt,
  output logic [csc_pkg::ID_W-1:0]      last_id_nxt,
  output logic                          wr_en,
  output logic [$clog2(DEPTH)-1:0]      wr_addr,
  output logic [csc_pkg::LEN_W-1:0]     wr_len,
  output logic [$clog2(DEPTH)-1:0]      rd_addr_a,
  output logic [$clog2(DEPTH)-1:0]      rd_addr_b,
  output csc_pkg::result_t              res
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0]           DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0]           DEPTH_SUM = SUM_W'(DEPTH);
  localparam logic [csc_pkg::TEXT_W-1:0] MAX_TXT   = csc_pkg::TEXT_W'(MAX_TEXT);

  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[PTR_W-1:0];
  endfunction

  csc_pkg::cmd_t                cmd;
  logic [csc_pkg::TEXT_W-1:0]   clamp;
  logic [csc_pkg::LEN_W-1:0]    new_len;
  logic                         try_en;
  logic [csc_pkg::LEN_W-1:0]    cand_len;
  logic [csc_pkg::LIMIT_W:0]    fill_sum;
  logic [CNT_W-1:0]             waiting;

  always_comb begin
    cmd             = csc_pkg::cmd_t'(command);
    clamp           = (text_length > MAX_TXT) ? MAX_TXT : text_length;
    new_len         = clamp[csc_pkg::LEN_W-1:0] + csc_pkg::LEN_W'(1);
    head_nxt        = head_r;
    entry_nxt       = entry_r;
    sent_nxt        = sent_r;
    outstanding_nxt = outstanding_r;
    last_id_nxt     = last_id_r;
    wr_en           = 1'b0;
    wr_addr         = slot_of(head_r, entry_r);
    wr_len          = new_len;
    res             = '0;
    try_en          = 1'b0;
    cand_len        = rd_len_a;

    if (item_valid) begin
      case (cmd)
        csc_pkg::CMD_ISSUE: begin
          if (link_active) begin
            if (entry_r == DEPTH_CNT) begin
              res.queue_full = 1'b1;
            end else begin
              wr_en           = 1'b1;
              entry_nxt       = entry_r + CNT_W'(1);
              last_id_nxt     = last_id_r + csc_pkg::ID_W'(1);
              res.accepted    = 1'b1;
              res.assigned_id = last_id_nxt;
              try_en          = 1'b1;
              cand_len        = (sent_r == entry_r) ? new_len : rd_len_a;
            end
          end
        end
        csc_pkg::CMD_OK, csc_pkg::CMD_FAULT: begin
          if (entry_r == '0) begin
            res.stray_reply = 1'b1;
          end else begin
            res.done_valid = 1'b1;
            res.done_id    = last_id_r - csc_pkg::ID_W'(entry_r) + csc_pkg::ID_W'(1);
            res.done_error = (cmd == csc_pkg::CMD_FAULT);
            if (sent_r != '0) begin
              outstanding_nxt = (outstanding_r >= csc_pkg::LIMIT_W'(rd_len_b)) ?
                                outstanding_r - csc_pkg::LIMIT_W'(rd_len_b) : '0;
              sent_nxt        = sent_r - CNT_W'(1);
            end
            head_nxt  = slot_of(head_r, CNT_W'(1));
            entry_nxt = entry_r - CNT_W'(1);
            try_en    = 1'b1;
            cand_len  = (sent_r != '0) ? rd_len_a : rd_len_b;
          end
        end
        default: begin
        end
      endcase
    end

    fill_sum = {1'b0, outstanding_nxt} + (csc_pkg::LIMIT_W + 1)'(cand_len);
    waiting  = entry_nxt - sent_nxt;
    if (try_en && (sent_nxt < entry_nxt) && (fill_sum <= {1'b0, receive_limit})) begin
      res.send_valid  = 1'b1;
      res.send_length = cand_len;
      res.send_id     = last_id_nxt - csc_pkg::ID_W'(waiting) + csc_pkg::ID_W'(1);
      outstanding_nxt = fill_sum[csc_pkg::LIMIT_W-1:0];
      sent_nxt        = sent_nxt + CNT_W'(1);
    end

    rd_addr_a = slot_of(head_nxt, sent_nxt);
    rd_addr_b = slot_of(head_nxt, (sent_nxt == '0) ? CNT_W'(1) : CNT_W'(0));
  end

endmodule

@@ rtl/command_stream_credit_control.sv @@
// ----------------------------------------------------------------------------
// command_stream_credit_control
// Character-counting flow control for a command stream to a controller with
// a small receive buffer.
// ----------------------------------------------------------------------------
// The block takes one beat in every cycle and busy stays low. Each beat is
// registered at the input, worked in one cycle of logic and registered at
// the output, so its single result appears with out_strobe two cycles after
// start, for exactly one cycle: the receiver cannot stall it and must take
// it then. Every beat gives a result, including rejected issues and unused
// command codes. The length store prefetches the two entries the next beat
// may need through its two registered read ports, which sets the one-cycle
// step. Configuration writes take effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
module command_stream_credit_control #(
  parameter int unsigned QUEUE_DEPTH = csc_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned MAX_TEXT    = csc_pkg::DEF_MAX_TEXT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [csc_pkg::CMD_W-1:0]       in_command,
  input  logic [csc_pkg::TEXT_W-1:0]      in_text_length,
  input  logic                            cfg_we,
  input  logic [csc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                            out_strobe,
  output logic                            out_accepted,
  output logic [csc_pkg::ID_W-1:0]        out_assigned_id,
  output logic                            out_queue_full,
  output logic                            out_send_valid,
  output logic [csc_pkg::ID_W-1:0]        out_send_id,
  output logic [csc_pkg::LEN_W-1:0]       out_send_length,
  output logic                            out_done_valid,
  output logic [csc_pkg::ID_W-1:0]        out_done_id,
  output logic                            out_done_error,
  output logic                            out_stray_reply
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                          in_valid_r;
  logic [csc_pkg::CMD_W-1:0]     cmd_r;
  logic [csc_pkg::TEXT_W-1:0]    text_r;

  logic [csc_pkg::LIMIT_W-1:0]   receive_limit_r;
  logic                          link_active_r;

  logic [PTR_W-1:0]              head_r;
  logic [PTR_W-1:0]              head_nxt;
  logic [CNT_W-1:0]              entry_r;
  logic [CNT_W-1:0]              entry_nxt;
  logic [CNT_W-1:0]              sent_r;
  logic [CNT_W-1:0]              sent_nxt;
  logic [csc_pkg::LIMIT_W-1:0]   outstanding_r;
  logic [csc_pkg::LIMIT_W-1:0]   outstanding_nxt;
  logic [csc_pkg::ID_W-1:0]      last_id_r;
  logic [csc_pkg::ID_W-1:0]      last_id_nxt;

  logic                          wr_en;
  logic [PTR_W-1:0]              wr_addr;
  logic [csc_pkg::LEN_W-1:0]     wr_len;
  logic [PTR_W-1:0]              rd_addr_a;
  logic [PTR_W-1:0]              rd_addr_b;
  logic [csc_pkg::LEN_W-1:0]     rd_len_a;
  logic [csc_pkg::LEN_W-1:0]     rd_len_b;

  csc_pkg::result_t              res;
  csc_pkg::result_t              res_r;
  logic                          strobe_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r  <= in_command;
      text_r <= in_text_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receive_limit_r <= csc_pkg::LIMIT_RESET;
      link_active_r   <= csc_pkg::LINK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        csc_pkg::CFG_RECEIVE_LIMIT: receive_limit_r <= cfg_wdata;
        csc_pkg::CFG_LINK_ACTIVE:   link_active_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  csc_step #(
    .DEPTH    (QUEUE_DEPTH),
    .MAX_TEXT (MAX_TEXT)
  ) u_step (
    .item_valid      (in_valid_r),
    .command         (cmd_r),
    .text_length     (text_r),
    .receive_limit   (receive_limit_r),
    .link_active     (link_active_r),
    .head_r          (head_r),
    .entry_r         (entry_r),
    .sent_r          (sent_r),
    .outstanding_r   (outstanding_r),
    .last_id_r       (last_id_r),
    .rd_len_a        (rd_len_a),
    .rd_len_b        (rd_len_b),
    .head_nxt        (head_nxt),
    .entry_nxt       (entry_nxt),
    .sent_nxt        (sent_nxt),
    .outstanding_nxt (outstanding_nxt),
    .last_id_nxt     (last_id_nxt),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_len          (wr_len),
    .rd_addr_a       (rd_addr_a),
    .rd_addr_b       (rd_addr_b),
    .res             (res)
  );

  csc_len_store #(
    .DEPTH (QUEUE_DEPTH)
  ) u_len_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_len),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_len_a),
    .rd_data_b (rd_len_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      entry_r       <= '0;
      sent_r        <= '0;
      outstanding_r <= '0;
      last_id_r     <= '0;
      strobe_r      <= 1'b0;
    end else begin
      head_r        <= head_nxt;
      entry_r       <= entry_nxt;
      sent_r        <= sent_nxt;
      outstanding_r <= outstanding_nxt;
      last_id_r     <= last_id_nxt;
      strobe_r      <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      res_r <= res;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_accepted    = res_r.accepted;
  assign out_assigned_id = res_r.assigned_id;
  assign out_queue_full  = res_r.queue_full;
  assign out_send_valid  = res_r.send_valid;
  assign out_send_id     = res_r.send_id;
  assign out_send_length = res_r.send_length;
  assign out_done_valid  = res_r.done_valid;
  assign out_done_id     = res_r.done_id;
  assign out_done_error  = res_r.done_error;
  assign out_stray_reply = res_r.stray_reply;

endmodule
